@@ src/pnc_pkg.sv @@
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared widths and constants for the perfect number checker.
// ----------------------------------------------------------------------------
package pnc_pkg;

  parameter int NUM_WIDTH_DEF = 31;
  parameter int SUM_EXTRA     = 3;

endpackage

@@ src/pnc_in_if.sv @@
// ----------------------------------------------------------------------------
// pnc_in_if
// Input channel of the perfect number checker: one number per beat.
// ----------------------------------------------------------------------------
interface pnc_in_if #(
  parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [NUM_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

@@ src/pnc_out_if.sv @@
// ----------------------------------------------------------------------------
// pnc_out_if
// Result channel of the perfect number checker: flag and aliquot sum per beat.
// ----------------------------------------------------------------------------
interface pnc_out_if #(
  parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
);
  localparam int SumWidth = NUM_WIDTH + pnc_pkg::SUM_EXTRA;

  logic                valid;
  logic                ready;
  logic                is_perfect;
  logic [SumWidth-1:0] aliquot_sum;

  modport source (output valid, output is_perfect, output aliquot_sum, input ready);
  modport sink   (input valid, input is_perfect, input aliquot_sum, output ready);
endinterface

@@ src/pnc_div.sv @@
// ----------------------------------------------------------------------------
// pnc_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnc_div #(
  parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] dividend_i,
  input  logic [NUM_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [NUM_WIDTH-1:0] quotient_o,
  output logic [NUM_WIDTH-1:0] remainder_o
);

  localparam int CntWidth = $clog2(NUM_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [NUM_WIDTH-1:0] quo_q, quo_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] dvs_q, dvs_d;
  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   trial;

  assign shifted = {rem_q, quo_q[NUM_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(NUM_WIDTH);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_WIDTH-2:0], ~trial[NUM_WIDTH]};
      rem_d = trial[NUM_WIDTH] ? shifted[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  as_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  as_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero step count");

  as_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_q && busy_q)
    else $error("divider start did not begin a division");

endmodule

@@ src/perfect_number_check.sv @@
// ----------------------------------------------------------------------------
// perfect_number_check
// Aliquot sum by trial division up to the square root, with perfect flag.
// ----------------------------------------------------------------------------
//   channel  dir  fields                     handshake
//   in_i     in   number                     valid / ready
//   out_o    out  is_perfect, aliquot_sum    valid / ready
//
// each trial divisor runs through the shared restoring divider; a divisor that
// divides is added in ST_ACC_D and its cofactor, if different, in ST_ACC_Q
// inputs 0 and 1 skip the divider and go straight to the finish state
// asynchronous active-low reset; ready is high in the first cycle after reset
// the result sits in an output register, so a new beat is taken while it waits;
// a second result waits in the finish state until the register is free
// ----------------------------------------------------------------------------
module perfect_number_check #(
  parameter int NUM_WIDTH = pnc_pkg::NUM_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnc_in_if.sink    in_i,
  pnc_out_if.source out_o
);

  localparam int SumWidth = NUM_WIDTH + pnc_pkg::SUM_EXTRA;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_ACC_D = 5'b00100,
    ST_ACC_Q = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic                 start_q, start_d;
  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic [SumWidth-1:0]  acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_perfect_q, out_perfect_d;
  logic [SumWidth-1:0]  out_sum_q, out_sum_d;

  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;
  logic [NUM_WIDTH-1:0] add_op;
  logic [SumWidth-1:0]  acc_sum;

  pnc_div #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // shared accumulator adder
  assign add_op  = (state_q == ST_ACC_Q) ? div_quo : d_q;
  assign acc_sum = acc_q + SumWidth'(add_op);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    start_d       = 1'b0;
    n_d           = n_q;
    d_d           = d_q;
    acc_d         = acc_q;
    out_valid_d   = out_valid_q;
    out_perfect_d = out_perfect_q;
    out_sum_d     = out_sum_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d = in_i.number;
          d_d = NUM_WIDTH'(2);
          if (in_i.number <= NUM_WIDTH'(1)) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else begin
            acc_d   = SumWidth'(1);
            start_d = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_q > div_quo) begin
            state_d = ST_FIN;
          end else if (div_rem == '0) begin
            state_d = ST_ACC_D;
          end else begin
            d_d     = d_q + NUM_WIDTH'(1);
            start_d = 1'b1;
          end
        end
      end
      ST_ACC_D: begin
        acc_d = acc_sum;
        if (div_quo != d_q) begin
          state_d = ST_ACC_Q;
        end else begin
          d_d     = d_q + NUM_WIDTH'(1);
          start_d = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_ACC_Q: begin
        acc_d   = acc_sum;
        d_d     = d_q + NUM_WIDTH'(1);
        start_d = 1'b1;
        state_d = ST_DIV;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_perfect_d = (acc_q != '0) && (acc_q == SumWidth'(n_q));
          out_sum_d     = acc_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    d_q           <= d_d;
    acc_q         <= acc_d;
    out_perfect_q <= out_perfect_d;
    out_sum_q     <= out_sum_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_perfect  = out_perfect_q;
  assign out_o.aliquot_sum = out_sum_q;

  as_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (d_q >= NUM_WIDTH'(2)))
    else $error("trial divisor below two");

  as_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV) && !start_q)
    else $error("divider result outside the divide state");

  as_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start work");

  as_add_only_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC_D) |-> (div_rem == '0))
    else $error("adding a trial value that does not divide");

endmodule
